// ===== sv/cfifo_pkg.sv =====
// Package for the circular FIFO with search.
// Holds operation and result codes, controller states and the
// command/status structs shared by the controller and datapath.
`default_nettype none

package cfifo_pkg;

    typedef enum logic [1:0] {
        FUNC_PUSH  = 2'd0,
        FUNC_POP   = 2'd1,
        FUNC_CLEAR = 2'd2,
        FUNC_FIND  = 2'd3
    } func_t;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_FULL      = 3'd1,
        ST_EMPTY     = 3'd2,
        ST_FOUND     = 3'd3,
        ST_NOT_FOUND = 3'd4
    } status_t;

    typedef enum logic {
        S_IDLE = 1'b0,
        S_RUN  = 1'b1
    } state_t;

    // controller -> datapath
    typedef struct packed {
        logic    load;     // take a request, read the head entry
        logic    advance;  // read the next entry of a find
        logic    push;
        logic    pop;
        logic    clear;
        logic    emit;     // write the output register
        status_t code;
    } cmd_t;

    // datapath -> controller
    typedef struct packed {
        func_t func;
        logic  empty;
        logic  full;
        logic  match;      // entry under the scan equals the search word
        logic  last;       // entry under the scan is the tail-most live one
        logic  out_free;   // output register can take a result this cycle
    } stat_t;

endpackage

`default_nettype wire

// ===== sv/cfifo_ctrl.sv =====
// Controller of the circular FIFO with search.
// Sequences one request at a time; depends on cfifo_pkg.
`default_nettype none

module cfifo_ctrl
    import cfifo_pkg::*;
(
    input  wire   clk,
    input  wire   rst_n,
    input  wire   in_valid,
    output logic  in_stall,
    input  stat_t stat,
    output cmd_t  cmd
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        cmd.code   = ST_OK;
        in_stall   = 1'b1;
        unique case (state_reg)
            S_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_RUN;
                end
            end
            S_RUN:
            begin
                unique case (stat.func)
                    FUNC_PUSH:
                    begin
                        if (stat.out_free)
                        begin
                            cmd.emit = 1'b1;
                            if (stat.full)
                            begin
                                cmd.code = ST_FULL;
                            end
                            else
                            begin
                                cmd.push = 1'b1;
                            end
                        end
                    end
                    FUNC_POP:
                    begin
                        if (stat.out_free)
                        begin
                            cmd.emit = 1'b1;
                            if (stat.empty)
                            begin
                                cmd.code = ST_EMPTY;
                            end
                            else
                            begin
                                cmd.pop = 1'b1;
                            end
                        end
                    end
                    FUNC_CLEAR:
                    begin
                        if (stat.out_free)
                        begin
                            cmd.emit  = 1'b1;
                            cmd.clear = 1'b1;
                            cmd.code  = stat.empty ? ST_EMPTY : ST_OK;
                        end
                    end
                    FUNC_FIND:
                    begin
                        priority if (stat.empty)
                        begin
                            cmd.emit = stat.out_free;
                            cmd.code = ST_EMPTY;
                        end
                        else if (stat.match)
                        begin
                            cmd.emit = stat.out_free;
                            cmd.code = ST_FOUND;
                        end
                        else if (stat.last)
                        begin
                            cmd.emit = stat.out_free;
                            cmd.code = ST_NOT_FOUND;
                        end
                        else
                        begin
                            cmd.advance = 1'b1;
                        end
                    end
                    default:
                    begin
                        cmd.emit = 1'b0;
                    end
                endcase
                if (cmd.emit)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== sv/cfifo_dp.sv =====
// Datapath of the circular FIFO with search: slot memory, pointers,
// fill count, scan walker and output register. Depends on cfifo_pkg.
`default_nettype none

module cfifo_dp
    import cfifo_pkg::*;
#(
    parameter int DEPTH = 8
)
(
    input  wire                clk,
    input  wire                rst_n,
    input  wire  [1:0]         func,
    input  wire  signed [31:0] value,
    input  cmd_t               cmd,
    output stat_t              stat,
    output logic               out_valid,
    input  wire                out_stall,
    output logic [2:0]         status,
    output logic signed [31:0] data,
    output logic [3:0]         position
);

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    logic signed [31:0] mem [DEPTH];

    logic [PW-1:0]      head_reg, head_next;
    logic [PW-1:0]      tail_reg, tail_next;
    logic [CW-1:0]      count_reg, count_next;
    logic [PW-1:0]      scan_ptr_reg, scan_ptr_next;
    logic [PW-1:0]      scan_k_reg, scan_k_next;
    func_t              func_reg;
    logic signed [31:0] val_reg;
    logic signed [31:0] rd_data_reg;
    logic               out_valid_reg;
    logic [2:0]         status_reg;
    logic signed [31:0] data_reg;
    logic [3:0]         position_reg;

    logic [PW-1:0]      rd_addr;
    logic               rd_en;
    logic [CW-1:0]      k_plus1;
    logic [CW+3:0]      pos_wide;

    function automatic logic [PW-1:0] wrap_inc(input logic [PW-1:0] p);
        logic [PW-1:0] r;
        if (p == PW'(DEPTH - 1))
        begin
            r = '0;
        end
        else
        begin
            r = p + PW'(1);
        end
        return r;
    endfunction

    // read port: head on a new request, then one entry a cycle during a find
    assign rd_addr = cmd.load ? head_reg : scan_ptr_reg;
    assign rd_en   = cmd.load | cmd.advance;

    always_ff @(posedge clk)
    begin
        if (cmd.push)
        begin
            mem[tail_reg] <= val_reg;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_comb
    begin
        head_next     = head_reg;
        tail_next     = tail_reg;
        count_next    = count_reg;
        scan_ptr_next = scan_ptr_reg;
        scan_k_next   = scan_k_reg;
        if (cmd.load)
        begin
            scan_ptr_next = wrap_inc(head_reg);
            scan_k_next   = '0;
        end
        if (cmd.advance)
        begin
            scan_ptr_next = wrap_inc(scan_ptr_reg);
            scan_k_next   = scan_k_reg + PW'(1);
        end
        if (cmd.push)
        begin
            tail_next  = wrap_inc(tail_reg);
            count_next = count_reg + CW'(1);
        end
        if (cmd.pop)
        begin
            head_next  = wrap_inc(head_reg);
            count_next = count_reg - CW'(1);
        end
        if (cmd.clear)
        begin
            head_next  = '0;
            tail_next  = '0;
            count_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg      <= '0;
            tail_reg      <= '0;
            count_reg     <= '0;
            scan_ptr_reg  <= '0;
            scan_k_reg    <= '0;
            func_reg      <= FUNC_PUSH;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            head_reg     <= head_next;
            tail_reg     <= tail_next;
            count_reg    <= count_next;
            scan_ptr_reg <= scan_ptr_next;
            scan_k_reg   <= scan_k_next;
            if (cmd.load)
            begin
                func_reg <= func_t'(func);
            end
            if (cmd.emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // position is carried modulo 16
    assign k_plus1  = CW'(scan_k_reg) + CW'(1);
    assign pos_wide = {4'b0000, k_plus1};

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            val_reg <= value;
        end
        if (cmd.emit)
        begin
            status_reg   <= cmd.code;
            data_reg     <= cmd.pop ? rd_data_reg : 32'sd0;
            position_reg <= (cmd.code == ST_FOUND) ? pos_wide[3:0] : 4'd0;
        end
    end

    always_comb
    begin
        stat.func     = func_reg;
        stat.empty    = (count_reg == '0);
        stat.full     = (count_reg == CW'(DEPTH));
        stat.match    = (rd_data_reg == val_reg);
        stat.last     = (k_plus1 >= count_reg);
        stat.out_free = !out_valid_reg || !out_stall;
    end

    assign out_valid = out_valid_reg;
    assign status    = status_reg;
    assign data      = data_reg;
    assign position  = position_reg;

endmodule

`default_nettype wire

// ===== sv/circular_fifo_with_search_top.sv =====
// Top level of the circular FIFO with search.
// Joins cfifo_ctrl and cfifo_dp; depends on cfifo_pkg.
//
//  channel | direction | handshake           | payload
//  --------+-----------+---------------------+-------------------------
//  in      | to block  | in_valid / in_stall | func, value
//  out     | from block| out_valid/out_stall | status, data, position
//
// One request at a time: the next is accepted only once the last result is
// written. Push, pop and clear reach the output register from the run state
// after the accept. Find compares entries in order from the head and reaches
// it on a match, on the tail-most live entry or at once on an empty queue; the
// single memory read port walks one entry a cycle. A new request is taken while
// a result waits in the output register.
// Reset is asynchronous, active low; slot contents are not cleared.
// A stalled output holds the request in progress until the register frees.
`default_nettype none

module circular_fifo_with_search_top
    import cfifo_pkg::*;
#(
    parameter int DEPTH = 8
)
(
    input  wire                clk,
    input  wire                rst_n,
    input  wire                in_valid,
    output logic               in_stall,
    input  wire  [1:0]         func,
    input  wire  signed [31:0] value,
    output logic               out_valid,
    input  wire                out_stall,
    output logic [2:0]         status,
    output logic signed [31:0] data,
    output logic [3:0]         position
);

    cmd_t  cmd;
    stat_t stat;

    cfifo_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .stat     (stat),
        .cmd      (cmd)
    );

    cfifo_dp #(
        .DEPTH (DEPTH)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .func      (func),
        .value     (value),
        .cmd       (cmd),
        .stat      (stat),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .status    (status),
        .data      (data),
        .position  (position)
    );

endmodule

`default_nettype wire

// ===== sv/cfifo_chk.sv =====
// Port-level checker for the circular FIFO with search, bound to the top.
// Depends on cfifo_pkg for the result codes.
`default_nettype none

module cfifo_chk
    import cfifo_pkg::*;
(
    input wire               clk,
    input wire               rst_n,
    input wire               out_valid,
    input wire               out_stall,
    input wire [2:0]         status,
    input wire signed [31:0] data,
    input wire [3:0]         position
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(status) && $stable(data)
            && $stable(position))
        else $error("stalled result changed");

    a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> status <= ST_NOT_FOUND)
        else $error("status code out of range");

    a_data_only_on_ok: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && data != 32'sd0 |-> status == ST_OK)
        else $error("data set on a failed or non-pop request");

    a_pos_only_on_found: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && position != 4'd0 |-> status == ST_FOUND)
        else $error("position set without a match");

endmodule

bind circular_fifo_with_search_top cfifo_chk u_chk (
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .data      (data),
    .position  (position)
);

`default_nettype wire

// ===== tb/circular_fifo_with_search_top_tb.sv =====
// Testbench for circular_fifo_with_search_top: push, pop, clear and find requests
// are checked against a cycle-free queue model kept inside this file.
// Depends on cfifo_pkg and the RTL only.
`timescale 1ns / 100ps

module circular_fifo_with_search_top_tb;
    import cfifo_pkg::*;

    localparam int DEPTH       = 8;
    localparam int HOLD_CYCLES = 80;
    localparam int MAX_REPORTS = 10;
    localparam int RUN_LIMIT   = 400000;   // ns

    typedef struct {
        func_t       op;
        logic [31:0] word;
    } fifo_req_t;

    typedef struct {
        logic [2:0]  status;
        logic [31:0] data;
        logic [3:0]  position;
    } fifo_result_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               in_valid = 1'b0;
    logic               in_stall;
    logic [1:0]         func = FUNC_PUSH;
    logic signed [31:0] value = '0;
    logic               out_valid;
    logic               out_stall = 1'b0;
    logic [2:0]         status;
    logic signed [31:0] data;
    logic [3:0]         position;

    fifo_req_t    pending_reqs[$];
    fifo_result_t expected_results[$];
    logic         in_taken = 1'b0;
    int           send_idle_pct = 0;
    int           recv_idle_pct = 0;
    int           hold_left = 0;
    int           mismatches = 0;
    int           requests_done = 0;
    int           status_count[5];
    logic [31:0]  word_pool[6];

    // queue model state
    logic [31:0]  q_slots[DEPTH];
    int unsigned  q_head = 0;
    int unsigned  q_tail = 0;
    int unsigned  q_fill = 0;

    circular_fifo_with_search_top #(.DEPTH(DEPTH)) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .func      (func),
        .value     (value),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .status    (status),
        .data      (data),
        .position  (position)
    );

    always #1 clk = ~clk;

    initial
    begin
        #(RUN_LIMIT);
        $display("Timeout: %0d results still awaited", expected_results.size());
        $display("*** FAILED ***");
        $finish;
    end

    function automatic int unsigned ring_next(int unsigned idx);
        return (idx + 1 >= DEPTH) ? 0 : idx + 1;
    endfunction

    // Applies one request to the queue model and returns the result it yields.
    function automatic fifo_result_t queue_apply(func_t op, logic [31:0] word);
        fifo_result_t res;
        int unsigned  idx;
        res.status   = ST_OK;
        res.data     = '0;
        res.position = '0;
        case (op)
            FUNC_PUSH:
            begin
                if (q_fill >= DEPTH)
                    res.status = ST_FULL;
                else
                begin
                    q_slots[q_tail] = word;
                    q_tail = ring_next(q_tail);
                    q_fill++;
                end
            end
            FUNC_POP:
            begin
                if (q_fill == 0)
                    res.status = ST_EMPTY;
                else
                begin
                    res.data = q_slots[q_head];
                    q_head = ring_next(q_head);
                    q_fill--;
                end
            end
            FUNC_CLEAR:
            begin
                if (q_fill == 0)
                    res.status = ST_EMPTY;
                q_head = 0;
                q_tail = 0;
                q_fill = 0;
            end
            default:
            begin
                if (q_fill == 0)
                    res.status = ST_EMPTY;
                else
                begin
                    res.status = ST_NOT_FOUND;
                    idx = q_head;
                    for (int k = 0; k < q_fill; k++)
                    begin
                        if (q_slots[idx] == word)
                        begin
                            res.status   = ST_FOUND;
                            res.position = 4'(k + 1);
                            break;
                        end
                        idx = ring_next(idx);
                    end
                end
            end
        endcase
        return res;
    endfunction

    task automatic note_mismatch(string msg);
        mismatches++;
        if (mismatches <= MAX_REPORTS)
            $display("ERROR @%0t: %s", $realtime, msg);
    endtask

    task automatic queue_request(func_t op, logic [31:0] word);
        fifo_req_t r;
        r.op   = op;
        r.word = word;
        pending_reqs.push_back(r);
    endtask

    function automatic logic [31:0] pick_word();
        if ($urandom_range(99) < 60)
            return word_pool[$urandom_range(5)];
        return $urandom;
    endfunction

    // Mostly pushes and pops so the queue sweeps between empty and full;
    // the mix shifts every few dozen requests.
    task automatic queue_random(int count);
        int push_pct;
        int r;
        push_pct = 45;
        for (int n = 0; n < count; n++)
        begin
            if (n % 40 == 0)
                push_pct = $urandom_range(25, 65);
            r = $urandom_range(99);
            if (r < push_pct)
                queue_request(FUNC_PUSH, pick_word());
            else if (r < 96 && r % 2 == 0)
                queue_request(FUNC_POP, $urandom);
            else if (r < 96)
                queue_request(FUNC_FIND, pick_word());
            else
                queue_request(FUNC_CLEAR, $urandom);
        end
    endtask

    task automatic refresh_pool();
        word_pool[0] = 32'h8000_0000;
        word_pool[1] = 32'h7fff_ffff;
        word_pool[2] = 32'hffff_ffff;
        for (int i = 3; i < 6; i++)
            word_pool[i] = $urandom;
    endtask

    task automatic wait_drained();
        while (pending_reqs.size() != 0 || expected_results.size() != 0)
            @(negedge clk);
    endtask

    // request driver: valid is held with a steady payload until taken
    always @(negedge clk)
    begin
        if (rst_n && (!in_valid || in_taken))
        begin
            if (pending_reqs.size() != 0 && $urandom_range(99) >= send_idle_pct)
            begin
                in_valid <= 1'b1;
                func     <= pending_reqs[0].op;
                value    <= pending_reqs[0].word;
            end
            else
                in_valid <= 1'b0;
        end
    end

    always @(negedge clk)
    begin
        if (rst_n)
            out_stall <= (hold_left > 0) || ($urandom_range(99) < recv_idle_pct);
    end

    // long receiver hold-off counter
    always @(posedge clk)
    begin
        if (hold_left > 0)
            hold_left <= hold_left - 1;
    end

    always @(posedge clk)
    begin : monitor
        fifo_result_t want;
        in_taken <= rst_n && in_valid && !in_stall;
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                if (expected_results.size() == 0)
                    note_mismatch($sformatf("unexpected result status=%0d data=%h pos=%0d",
                                            status, data, position));
                else
                begin
                    want = expected_results.pop_front();
                    if (status !== want.status || data !== want.data
                        || position !== want.position)
                        note_mismatch($sformatf(
                            "expected status=%0d data=%h pos=%0d, got status=%0d data=%h pos=%0d",
                            want.status, want.data, want.position, status, data, position));
                end
            end
            if (in_valid && !in_stall)
            begin
                want = queue_apply(func_t'(func), value);
                if (want.status < 5)
                    status_count[want.status]++;
                expected_results.push_back(want);
                void'(pending_reqs.pop_front());
                requests_done++;
            end
        end
    end

    initial
    begin
        foreach (status_count[i])
            status_count[i] = 0;
        foreach (q_slots[i])
            q_slots[i] = '0;
        refresh_pool();

        // phase 1: sender idles lightly, receiver heavily
        send_idle_pct = 12;
        recv_idle_pct = 50;
        queue_request(FUNC_POP, 32'h0);
        queue_request(FUNC_FIND, 32'h5);
        queue_request(FUNC_CLEAR, 32'h0);
        queue_request(FUNC_PUSH, 32'h8000_0000);
        queue_request(FUNC_PUSH, 32'h7fff_ffff);
        queue_request(FUNC_PUSH, 32'hffff_ffff);
        queue_request(FUNC_PUSH, 32'h0);
        queue_request(FUNC_FIND, 32'hffff_ffff);
        queue_request(FUNC_FIND, 32'h1234_5678);
        for (int i = 1; i <= 4; i++)
            queue_request(FUNC_PUSH, i);
        queue_request(FUNC_PUSH, 32'h5555_5555);    // rejected, queue full
        queue_request(FUNC_FIND, 32'h4);            // match in the last slot
        queue_request(FUNC_POP, 32'h0);
        queue_request(FUNC_PUSH, 32'haaaa_aaaa);    // tail wraps
        queue_request(FUNC_FIND, 32'haaaa_aaaa);
        queue_request(FUNC_FIND, 32'h7fff_ffff);
        queue_request(FUNC_POP, 32'h0);
        queue_request(FUNC_CLEAR, 32'h0);
        queue_request(FUNC_POP, 32'h0);

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        queue_random(290);
        wait_drained();

        // phase 2: roles swapped
        send_idle_pct = 50;
        recv_idle_pct = 12;
        refresh_pool();
        queue_random(290);
        wait_drained();

        // phase 3: no idling; receiver holds off while requests keep coming
        send_idle_pct = 0;
        recv_idle_pct = 0;
        refresh_pool();
        @(posedge clk);
        hold_left <= HOLD_CYCLES;
        queue_request(FUNC_CLEAR, 32'h0);
        for (int i = 0; i < 12; i++)
            queue_request(FUNC_PUSH, pick_word());
        queue_request(FUNC_FIND, word_pool[$urandom_range(5)]);
        queue_random(290);
        wait_drained();

        repeat (4 * DEPTH) @(posedge clk);

        $display("Ran %0d requests: %0d ok, %0d full, %0d empty, %0d found, %0d not found",
                 requests_done, status_count[ST_OK], status_count[ST_FULL],
                 status_count[ST_EMPTY], status_count[ST_FOUND], status_count[ST_NOT_FOUND]);
        $display("Mismatches: %0d (idle mixes on both sides plus a %0d-cycle output hold-off)",
                 mismatches, HOLD_CYCLES);
        if (mismatches == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
